// ===== rtl/core/ats_pkg.sv =====
`timescale 1ns / 1ps

package ats_pkg;

    localparam int KIND_W      = 1;
    localparam int TILE_ID_W   = 16;
    localparam int TIME_W      = 32;
    localparam int FTILE_W     = 12;
    localparam int FDUR_W      = 16;
    localparam int PIX_W       = 14;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 9;
    localparam int SHEET_DIM_W = 7;
    localparam int TILE_DIM_W  = 9;
    localparam int DIV_W       = 32;
    localparam int DIV_STEP_W  = 6;

    localparam logic [KIND_W-1:0] KIND_APPEND = 1'b0;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SHEET_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHEET_ROWS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT   = 2'd3;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV_TILE,
        ST_TREAD,
        ST_TDATA,
        ST_DIV_TIME,
        ST_WALK_RD,
        ST_WALK_CHK,
        ST_DIV_POS,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                  start;
        logic [DIV_W-1:0]      dividend;
        logic [DIV_W-1:0]      divisor;
        logic [DIV_STEP_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quo;
        logic [DIV_W-1:0] rem;
    } div_rsp_t;

endpackage

// ===== rtl/core/ats_req_if.sv =====
`timescale 1ns / 1ps

interface ats_req_if;
    logic                           valid;
    logic                           ready;
    logic [ats_pkg::KIND_W-1:0]     kind;
    logic [ats_pkg::TILE_ID_W-1:0]  tile_id;
    logic [ats_pkg::TIME_W-1:0]     time_now;
    logic [ats_pkg::FTILE_W-1:0]    frame_tile;
    logic [ats_pkg::FDUR_W-1:0]     frame_duration;

    modport source (output valid, kind, tile_id, time_now, frame_tile, frame_duration,
                    input ready);
    modport sink   (input valid, kind, tile_id, time_now, frame_tile, frame_duration,
                    output ready);
endinterface

// ===== rtl/core/ats_rsp_if.sv =====
`timescale 1ns / 1ps

interface ats_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [ats_pkg::PIX_W-1:0]    pixel_x;
    logic [ats_pkg::PIX_W-1:0]    pixel_y;
    logic [ats_pkg::FTILE_W-1:0]  shown_tile;

    modport source (output valid, pixel_x, pixel_y, shown_tile, input ready);
    modport sink   (input valid, pixel_x, pixel_y, shown_tile, output ready);
endinterface

// ===== rtl/core/ats_cfg_if.sv =====
`timescale 1ns / 1ps

interface ats_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [ats_pkg::CFG_IDX_W-1:0]    index;
    logic [ats_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/ats_ram.sv =====
`timescale 1ns / 1ps

module ats_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/ats_div.sv =====
`timescale 1ns / 1ps

module ats_div (
    input  logic               clk,
    input  logic               rst_n,
    input  ats_pkg::div_req_t  req,
    output ats_pkg::div_rsp_t  rsp
);
    import ats_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_STEP_W-1:0] cnt_reg;
    logic [DIV_W-1:0]      dvd_reg;
    logic [DIV_W-1:0]      dvs_reg;
    logic [DIV_W-1:0]      quo_reg;
    logic [DIV_W-1:0]      rem_reg;
    logic [DIV_W:0]        trial;
    logic                  fits;
    logic [DIV_W-1:0]      rem_next;

    // restoring division, one quotient bit a cycle from the top of the dividend
    assign trial    = {rem_reg, dvd_reg[DIV_W-1]};
    assign fits     = trial >= {1'b0, dvs_reg};
    assign rem_next = fits ? DIV_W'(trial - {1'b0, dvs_reg}) : DIV_W'(trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
            quo_reg <= '0;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DIV_W-2:0], 1'b0};
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

// ===== rtl/core/animated_tile_sheet_locator.sv =====
`timescale 1ns / 1ps

// Animated tile sheet locator. Keeps up to MAX_FRAMES animation frames for each of
// NUM_TILES tiles in two single-port-write RAMs (per-tile count and total duration,
// and the frame list) and answers lookups with the sheet pixel position of the frame
// shown at a given time. NUM_TILES must be a power of two: the table slot is the low
// bits of the tile number. After reset the block sweeps the tile table to zero, one
// entry a cycle, and takes no item until done. Write the configuration registers
// only while no item is in flight. Items are handled one at a time. After an append
// is accepted, ready stays low while the table is read and then the table and frame
// are written. After a lookup it stays low while the shared bit-serial divider
// reduces the tile number by the sheet area (16 steps), the table is read, the
// divider takes the time modulo the total duration (32 steps) and the frames are
// walked, each read and checked, up to the one shown (both skipped for an unanimated
// tile), and the divider splits the shown tile into column and row (14 steps); then
// the output is loaded. A result waits in an output register while the next item is
// taken; a lookup that finishes while an earlier result is still untaken holds until
// that result is taken.
module animated_tile_sheet_locator #(
    parameter int NUM_TILES  = 4096,
    parameter int MAX_FRAMES = 8
) (
    input  logic clk,
    input  logic rst_n,
    ats_req_if.sink   req,
    ats_rsp_if.source rsp,
    ats_cfg_if.sink   cfg
);
    import ats_pkg::*;

    localparam int SLOT_W  = (NUM_TILES > 1) ? $clog2(NUM_TILES) : 1;
    localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
    localparam int TOT_W   = FDUR_W + CNT_W;
    localparam int TBL_W   = CNT_W + TOT_W;
    localparam int FRM_D   = NUM_TILES * MAX_FRAMES;
    localparam int ADDR_W  = (FRM_D > 1) ? $clog2(FRM_D) : 1;
    localparam int FRM_W   = FTILE_W + FDUR_W;
    localparam int SHOWN_W = 2 * SHEET_DIM_W;

    localparam logic [CNT_W-1:0]  MAX_CNT       = CNT_W'(MAX_FRAMES);
    localparam logic [SLOT_W-1:0] LAST_SLOT     = SLOT_W'(NUM_TILES - 1);
    localparam logic [ADDR_W-1:0] FRAMES_A      = ADDR_W'(MAX_FRAMES);

    // configuration registers
    logic [SHEET_DIM_W-1:0] cols_reg;
    logic [SHEET_DIM_W-1:0] rows_reg;
    logic [TILE_DIM_W-1:0]  width_reg;
    logic [TILE_DIM_W-1:0]  height_reg;

    state_t state_reg;
    state_t state_next;

    logic [SLOT_W-1:0]  clr_reg;
    logic [KIND_W-1:0]  kind_reg;
    logic [TIME_W-1:0]  time_reg;
    logic [FTILE_W-1:0] ftile_reg;
    logic [FDUR_W-1:0]  fdur_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [ADDR_W-1:0]  base_reg;
    logic [SHOWN_W-1:0] shown_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   f_reg;
    logic [TOT_W-1:0]   t_reg;
    logic [TOT_W-1:0]   sum_reg;
    logic [PIX_W-1:0]   px_reg;
    logic [PIX_W-1:0]   py_reg;

    logic               out_valid_reg;
    logic [PIX_W-1:0]   out_x_reg;
    logic [PIX_W-1:0]   out_y_reg;
    logic [FTILE_W-1:0] out_tile_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    // memories
    logic               tbl_we;
    logic [SLOT_W-1:0]  tbl_waddr;
    logic [TBL_W-1:0]   tbl_wdata;
    logic [TBL_W-1:0]   tbl_rdata;
    logic               frm_we;
    logic [ADDR_W-1:0]  frm_addr;
    logic [FRM_W-1:0]   frm_rdata;

    logic [SHEET_DIM_W-1:0]   cols_eff;
    logic [SHEET_DIM_W-1:0]   rows_eff;
    logic [2*SHEET_DIM_W-1:0] area;
    logic [CNT_W-1:0]         tbl_cnt;
    logic [TOT_W-1:0]         tbl_tot;
    logic [FTILE_W-1:0]       frm_tile;
    logic [FDUR_W-1:0]        frm_dur;
    logic [TOT_W-1:0]         sum_new;
    logic                     walk_hit;
    logic                     walk_end;
    logic                     pos_go;
    logic [SHOWN_W-1:0]       pos_tile;
    logic                     req_fire;
    logic                     out_free;

    assign cols_eff = (cols_reg == '0) ? SHEET_DIM_W'(1) : cols_reg;
    assign rows_eff = (rows_reg == '0) ? SHEET_DIM_W'(1) : rows_reg;
    assign area     = cols_eff * rows_eff;

    assign {tbl_cnt, tbl_tot}  = tbl_rdata;
    assign {frm_tile, frm_dur} = frm_rdata;
    assign sum_new  = sum_reg + TOT_W'(frm_dur);
    assign walk_hit = sum_new > t_reg;
    assign walk_end = (f_reg + 1'b1) == cnt_reg;

    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign cfg.ready = 1'b1;

    // config writes, taken at any time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg   <= SHEET_DIM_W'(1);
            rows_reg   <= SHEET_DIM_W'(1);
            width_reg  <= TILE_DIM_W'(16);
            height_reg <= TILE_DIM_W'(16);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_SHEET_COLUMNS: cols_reg   <= cfg.data[SHEET_DIM_W-1:0];
                REG_SHEET_ROWS:    rows_reg   <= cfg.data[SHEET_DIM_W-1:0];
                REG_TILE_WIDTH:    width_reg  <= cfg.data[TILE_DIM_W-1:0];
                REG_TILE_HEIGHT:   height_reg <= cfg.data[TILE_DIM_W-1:0];
                default:           cols_reg   <= cols_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state, divider launches and memory writes
    always_comb
    begin
        state_next = state_reg;
        pos_go     = 1'b0;
        pos_tile   = shown_reg;
        div_req    = '0;
        tbl_we     = 1'b0;
        tbl_waddr  = slot_reg;
        tbl_wdata  = {CNT_W'(tbl_cnt + 1'b1), TOT_W'(tbl_tot + TOT_W'(fdur_reg))};
        frm_we     = 1'b0;
        frm_addr   = base_reg + ADDR_W'(f_reg);

        case (state_reg)
            ST_CLEAR:
            begin
                tbl_we    = 1'b1;
                tbl_waddr = clr_reg;
                tbl_wdata = '0;
                if (clr_reg == LAST_SLOT)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.kind == KIND_LOOKUP)
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = {req.tile_id, {(DIV_W - TILE_ID_W){1'b0}}};
                        div_req.divisor  = DIV_W'(area);
                        div_req.steps    = DIV_STEP_W'(TILE_ID_W);
                        state_next       = ST_DIV_TILE;
                    end
                    else
                    begin
                        state_next = ST_TREAD;
                    end
                end
            end
            ST_DIV_TILE:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_TREAD;
                end
            end
            ST_TREAD:
            begin
                state_next = ST_TDATA;
            end
            ST_TDATA:
            begin
                frm_addr = base_reg + ADDR_W'(tbl_cnt);
                if (kind_reg == KIND_APPEND)
                begin
                    // drop the append once the frame list is full
                    if (tbl_cnt < MAX_CNT)
                    begin
                        tbl_we = 1'b1;
                        frm_we = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
                else if (tbl_tot == '0)
                begin
                    pos_go = 1'b1;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = time_reg;
                    div_req.divisor  = DIV_W'(tbl_tot);
                    div_req.steps    = DIV_STEP_W'(TIME_W);
                    state_next       = ST_DIV_TIME;
                end
            end
            ST_DIV_TIME:
            begin
                if (div_rsp.done)
                begin
                    if (cnt_reg == '0)
                    begin
                        pos_go = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_WALK_RD;
                    end
                end
            end
            ST_WALK_RD:
            begin
                state_next = ST_WALK_CHK;
            end
            ST_WALK_CHK:
            begin
                if (walk_hit)
                begin
                    pos_go   = 1'b1;
                    pos_tile = SHOWN_W'(frm_tile);
                end
                else if (walk_end)
                begin
                    pos_go = 1'b1;
                end
                else
                begin
                    state_next = ST_WALK_RD;
                end
            end
            ST_DIV_POS:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // split the shown tile into column and row
        if (pos_go)
        begin
            div_req.start    = 1'b1;
            div_req.dividend = {pos_tile, {(DIV_W - SHOWN_W){1'b0}}};
            div_req.divisor  = DIV_W'(cols_eff);
            div_req.steps    = DIV_STEP_W'(SHOWN_W);
            state_next       = ST_DIV_POS;
        end
    end

    // sweep counter for the clearing pass, frame count copy and walk index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
            f_reg   <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (state_reg == ST_TDATA)
            begin
                cnt_reg <= tbl_cnt;
            end
            if (state_reg == ST_DIV_TIME)
            begin
                f_reg <= '0;
            end
            else if (state_reg == ST_WALK_CHK && !walk_hit && !walk_end)
            begin
                f_reg <= f_reg + 1'b1;
            end
        end
    end

    // item payload and working values
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            kind_reg  <= req.kind;
            time_reg  <= req.time_now;
            ftile_reg <= req.frame_tile;
            fdur_reg  <= req.frame_duration;
            // appends index the table with the low bits of the tile number
            slot_reg  <= SLOT_W'(req.tile_id);
        end
        if (state_reg == ST_DIV_TILE && div_rsp.done)
        begin
            slot_reg  <= SLOT_W'(div_rsp.rem[SHOWN_W-1:0]);
            shown_reg <= div_rsp.rem[SHOWN_W-1:0];
        end
        if (state_reg == ST_TREAD)
        begin
            base_reg <= ADDR_W'(slot_reg) * FRAMES_A;
        end
        if (state_reg == ST_DIV_TIME)
        begin
            t_reg   <= div_rsp.rem[TOT_W-1:0];
            sum_reg <= '0;
        end
        if (state_reg == ST_WALK_CHK)
        begin
            sum_reg <= sum_new;
            if (walk_hit)
            begin
                shown_reg <= SHOWN_W'(frm_tile);
            end
        end
        if (state_reg == ST_DIV_POS && div_rsp.done)
        begin
            // keep the low bits: positions wrap at the field width
            px_reg <= PIX_W'(width_reg) * PIX_W'(div_rsp.rem[SHEET_DIM_W-1:0]);
            py_reg <= PIX_W'(height_reg) * div_rsp.quo[PIX_W-1:0];
        end
    end

    // output register: hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_OUT && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && out_free)
        begin
            out_x_reg    <= px_reg;
            out_y_reg    <= py_reg;
            out_tile_reg <= shown_reg[FTILE_W-1:0];
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.pixel_x    = out_x_reg;
    assign rsp.pixel_y    = out_y_reg;
    assign rsp.shown_tile = out_tile_reg;

    ats_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // per-tile frame count and total duration; read at slot_reg
    ats_ram #(
        .WIDTH (TBL_W),
        .DEPTH (NUM_TILES)
    ) u_tbl_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (slot_reg),
        .rdata (tbl_rdata)
    );

    // frame list, MAX_FRAMES entries per tile
    ats_ram #(
        .WIDTH (FRM_W),
        .DEPTH (FRM_D)
    ) u_frm_ram (
        .clk   (clk),
        .we    (frm_we),
        .waddr (frm_addr),
        .wdata ({ftile_reg, fdur_reg}),
        .raddr (frm_addr),
        .rdata (frm_rdata)
    );

`ifndef SYNTHESIS
    a_frm_write_on_append: assert property (@(posedge clk) disable iff (!rst_n)
        frm_we |-> (state_reg == ST_TDATA && kind_reg == KIND_APPEND))
        else $error("frame write outside an append");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result loaded outside the output state");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK_CHK) |-> (f_reg < cnt_reg))
        else $error("frame walk beyond the tile's frame count");

    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIV_TILE || state_reg == ST_DIV_TIME
                          || state_reg == ST_DIV_POS))
        else $error("divider finished with no one waiting");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import ats_pkg::*;

    localparam int NUM_TILES  = 4096;
    localparam int MAX_FRAMES = 8;

    typedef struct packed {
        logic [PIX_W-1:0]   pixel_x;
        logic [PIX_W-1:0]   pixel_y;
        logic [FTILE_W-1:0] shown_tile;
    } position_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ats_req_if req ();
    ats_rsp_if rsp ();
    ats_cfg_if cfg ();

    animated_tile_sheet_locator #(
        .NUM_TILES  (NUM_TILES),
        .MAX_FRAMES (MAX_FRAMES)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    always #5 clk = ~clk;

    // Shadow copy of the animation table and the sheet registers
    logic [6:0]  sh_cols, sh_rows;
    logic [8:0]  sh_width, sh_height;
    int unsigned frames_held [NUM_TILES];
    int unsigned total_dur   [NUM_TILES];
    logic [15:0] frame_dur   [NUM_TILES*MAX_FRAMES];
    logic [11:0] frame_tile  [NUM_TILES*MAX_FRAMES];

    position_t   pending_positions[$];
    int          errors = 0;
    int          positions_seen = 0;
    int          items_sent = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
        errors++;
    endtask

    // Work out the state change and the position of one accepted item
    task automatic predict_item(input logic kind, input logic [15:0] tile,
                                input logic [31:0] tnow, input logic [11:0] ftile,
                                input logic [15:0] fdur);
        int unsigned slot, n, cols, area, shown, t, sum, e;
        position_t pos;
        if (kind == KIND_APPEND) begin
            slot = tile % NUM_TILES;
            n = frames_held[slot];
            if (n < MAX_FRAMES) begin
                e = slot * MAX_FRAMES + n;
                frame_tile[e] = ftile;
                frame_dur[e] = fdur;
                frames_held[slot] = n + 1;
                total_dur[slot] += fdur;
            end
        end else begin
            cols = (sh_cols == 0) ? 1 : sh_cols;
            area = cols * ((sh_rows == 0) ? 1 : sh_rows);
            shown = tile % area;
            slot = shown % NUM_TILES;
            if (total_dur[slot] != 0) begin
                t = tnow % total_dur[slot];
                sum = 0;
                for (int f = 0; f < frames_held[slot]; f++) begin
                    e = slot * MAX_FRAMES + f;
                    sum += frame_dur[e];
                    if (sum > t) begin
                        shown = frame_tile[e];
                        break;
                    end
                end
            end
            pos.pixel_x = PIX_W'(sh_width * (shown % cols));
            pos.pixel_y = PIX_W'(sh_height * (shown / cols));
            pos.shown_tile = FTILE_W'(shown);
            pending_positions = {pending_positions, pos};
        end
    endtask

    // Send one item; hold valid until accepted
    task automatic send_item(input logic kind, input logic [15:0] tile,
                             input logic [31:0] tnow, input logic [11:0] ftile,
                             input logic [15:0] fdur);
        do
            @(posedge clk);
        while ($urandom_range(99) < send_idle_pct);
        req.valid <= 1'b1;
        req.kind <= kind;
        req.tile_id <= tile;
        req.time_now <= tnow;
        req.frame_tile <= ftile;
        req.frame_duration <= fdur;
        do @(posedge clk); while (!req.ready);
        predict_item(kind, tile, tnow, ftile, fdur);
        items_sent++;
        req.valid <= 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= CFG_DATA_W'(value);
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        case (idx)
            REG_SHEET_COLUMNS: sh_cols = value[6:0];
            REG_SHEET_ROWS:    sh_rows = value[6:0];
            REG_TILE_WIDTH:    sh_width = value[8:0];
            default:           sh_height = value[8:0];
        endcase
    endtask

    // Drain results, then allow a trailing append to finish
    task automatic wait_drained();
        while (pending_positions.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_sheet(input int cols, input int rows, input int w, input int h);
        wait_drained();
        write_reg(REG_SHEET_COLUMNS, cols);
        write_reg(REG_SHEET_ROWS, rows);
        write_reg(REG_TILE_WIDTH, w);
        write_reg(REG_TILE_HEIGHT, h);
    endtask

    // Check each accepted result against the oldest expected position
    always @(posedge clk) begin
        position_t want;
        if (rsp.valid && rsp.ready) begin
            positions_seen++;
            if (pending_positions.size() == 0) begin
                report_mismatch("unexpected result, shown_tile", rsp.shown_tile, -1);
            end else begin
                want = pending_positions.pop_front();
                if (rsp.pixel_x !== want.pixel_x)
                    report_mismatch("pixel_x", rsp.pixel_x, want.pixel_x);
                if (rsp.pixel_y !== want.pixel_y)
                    report_mismatch("pixel_y", rsp.pixel_y, want.pixel_y);
                if (rsp.shown_tile !== want.shown_tile)
                    report_mismatch("shown_tile", rsp.shown_tile, want.shown_tile);
            end
        end
        rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Directed: reset sheet, unanimated tiles, full list, zero durations, wide values
    task automatic test_directed();
        send_item(KIND_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, 12'hFFF, 16'hFFFF);
        set_sheet(0, 0, 16, 16);
        send_item(KIND_LOOKUP, 16'd5, 32'd0, 12'd0, 16'd0);
        set_sheet(64, 64, 256, 256);
        // tile 7: a zero frame, then frames of 3 and 5, then fill past the limit
        send_item(KIND_APPEND, 16'd7, 32'd0, 12'd100, 16'd0);
        send_item(KIND_APPEND, 16'd7, 32'd0, 12'hFFF, 16'd3);
        send_item(KIND_APPEND, 16'd7, 32'd0, 12'd200, 16'd5);
        for (int i = 0; i < 7; i++)
            send_item(KIND_APPEND, 16'd7 + 16'd4096, 32'd0, 12'(300 + i), 16'hFFFF);
        send_item(KIND_LOOKUP, 16'd7, 32'd0, 12'd0, 16'd0);
        send_item(KIND_LOOKUP, 16'd7, 32'd3, 12'd0, 16'd0);
        send_item(KIND_LOOKUP, 16'd7, 32'hFFFF_FFFF, 12'd0, 16'd0);
        send_item(KIND_LOOKUP, 16'd4096 + 16'd7, 32'd9, 12'd0, 16'd0);
        // reduced tiles up to 16128 with no animation, wide positions
        send_item(KIND_LOOKUP, 16'd4095, 32'd0, 12'd0, 16'd0);
        send_item(KIND_LOOKUP, 16'hFFFF, 32'd1, 12'd0, 16'd0);
        set_sheet(127, 127, 511, 511);
        send_item(KIND_LOOKUP, 16'd16128, 32'd0, 12'd0, 16'd0);
        send_item(KIND_LOOKUP, 16'hFFFF, 32'd0, 12'd0, 16'd0);
    endtask

    // Random: tiles drawn mostly within the sheet area so lookups land on animated tiles
    task automatic test_random(input int count);
        logic [15:0] tile;
        int limit;
        limit = (sh_cols == 0 ? 1 : sh_cols) * (sh_rows == 0 ? 1 : sh_rows);
        for (int i = 0; i < count; i++) begin
            tile = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(limit - 1));
            if ($urandom_range(2) == 0)
                send_item(KIND_APPEND, tile, $urandom,
                          12'($urandom), ($urandom_range(3) == 0) ? 16'($urandom)
                          : 16'($urandom_range(20)));
            else
                send_item(KIND_LOOKUP, tile, ($urandom_range(1) == 0) ? $urandom
                          : $urandom_range(200), 12'($urandom), 16'($urandom));
        end
    endtask

    task automatic test_pause();
        send_item(KIND_LOOKUP, 16'd1, 32'd1, 12'd0, 16'd0);
        while (pending_positions.size() != 0)
            @(posedge clk);
        send_item(KIND_LOOKUP, 16'd2, 32'd2, 12'd0, 16'd0);
    endtask

    initial begin
        req.valid = 1'b0;
        req.kind = KIND_APPEND;
        req.tile_id = '0;
        req.time_now = '0;
        req.frame_tile = '0;
        req.frame_duration = '0;
        cfg.valid = 1'b0;
        cfg.index = REG_SHEET_COLUMNS;
        cfg.data = '0;
        rsp.ready = 1'b0;
        sh_cols = 7'd1;
        sh_rows = 7'd1;
        sh_width = 9'd16;
        sh_height = 9'd16;
        foreach (frames_held[i]) begin
            frames_held[i] = 0;
            total_dur[i] = 0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        set_sheet(5, 3, 12, 7);
        test_random(500);
        send_idle_pct = 60;
        set_sheet(8, 8, 1, 1);
        test_random(500);
        send_idle_pct = 0;
        recv_stall_pct = 60;
        test_pause();
        set_sheet(3, 2, 256, 100);
        test_random(500);
        send_idle_pct = 24;
        recv_stall_pct = 24;
        set_sheet(64, 64, 9, 33);
        test_random(500);
        recv_stall_pct = 0;

        wait_drained();
        $display("Sent %0d items, checked %0d positions over eight sheet settings", items_sent,
                 positions_seen);
        $display("and four idle profiles, including full lists and wrapped positions.");
        if (errors == 0)
            $display("animated_tile_sheet_locator: match");
        else
            $display("animated_tile_sheet_locator: mismatch");
        $finish;
    end

    initial begin
        #20ms;
        $display("animated_tile_sheet_locator: mismatch");
        $finish;
    end
endmodule
